FILE: src/skoi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skoi_pkg
// Shared types and constants for the sorted key/offset index unit.
// ----------------------------------------------------------------------------
package skoi_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ID_W        = 31;
   localparam int OFF_W       = 40;
   localparam int DATA_W      = ((ID_W + OFF_W + 7) / 8) * 8;
   localparam int STATUS_W    = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ENTRY = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DRAIN  = 2'd2
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [ID_W-1:0]  key;
      logic [OFF_W-1:0] offset;
   } entry_type;

   typedef struct packed {
      cell_cmd_type     cmd;
      logic [ID_W-1:0]  key;
      logic [OFF_W-1:0] offset;
   } cell_ctrl_type;

endpackage

FILE: src/skoi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skoi_cell
// One slot of the sorted chain: holds a pair, takes the new pair, its left
// neighbour's pair on insert, or its right neighbour's pair on drain.
// ----------------------------------------------------------------------------
module skoi_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  skoi_pkg::cell_ctrl_type ctrl,
   input  logic                   left_open,
   input  skoi_pkg::entry_type    left_entry,
   input  skoi_pkg::entry_type    right_entry,
   output logic                   open,
   output skoi_pkg::entry_type    entry
);
   import skoi_pkg::*;

   logic             valid_ff, valid_in;
   logic [ID_W-1:0]  key_ff, key_in;
   logic [OFF_W-1:0] offset_ff, offset_in;

   // slot is free for the new key: empty or holding a strictly larger key
   assign open = !valid_ff || (key_ff > ctrl.key);

   assign entry.valid  = valid_ff;
   assign entry.key    = key_ff;
   assign entry.offset = offset_ff;

   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      offset_in = offset_ff;
      case (ctrl.cmd)
         CMD_INSERT: begin
            if (left_open) begin
               valid_in  = left_entry.valid;
               key_in    = left_entry.key;
               offset_in = left_entry.offset;
            end else if (open) begin
               valid_in  = 1'b1;
               key_in    = ctrl.key;
               offset_in = ctrl.offset;
            end
         end
         CMD_DRAIN: begin
            valid_in  = right_entry.valid;
            key_in    = right_entry.key;
            offset_in = right_entry.offset;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff    <= key_in;
      offset_ff <= offset_in;
   end

endmodule

FILE: src/sorted_key_offset_index_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_offset_index_unit
// Sorted index of (id, offset) pairs held in a chain of compare/shift cells.
//
//  channel | ports | tdata (low bit up)            | tuser  | tlast
//  --------+-------+-------------------------------+--------+-----------
//  input   | req_  | person_id, record_offset, pad | op     | -
//  result  | rsp_  | out_id, out_offset, pad       | status | last
//
// An accepted insert shifts the cell chain; inserts may follow back to back
// while the output register is free. A drain closes the input from acceptance
// until its last pair is out, moving one pair a cycle from the first cell into
// the output register while not stalled. Overflow and empty results use that
// register too. Reset clears the valid bits of all cells at once; no clearing
// pass. A stalled result holds the output register and, with it, the drain.
// ----------------------------------------------------------------------------
module sorted_key_offset_index_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [skoi_pkg::DATA_W-1:0]   req_tdata,   // person_id, record_offset
   input  logic                          req_tuser,   // op
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [skoi_pkg::DATA_W-1:0]   rsp_tdata,   // out_id, out_offset
   output logic                          rsp_tlast,
   output logic [skoi_pkg::STATUS_W-1:0] rsp_tuser    // status
);
   import skoi_pkg::*;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [OFF_W-1:0]     rsp_offset_ff, rsp_offset_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   cell_ctrl_type        ctrl;
   entry_type            ent  [TABLE_DEPTH];
   logic                 open [TABLE_DEPTH];

   logic                 accept;
   logic                 slot_free;
   logic                 full;
   logic [ID_W-1:0]      req_id;
   logic [OFF_W-1:0]     req_offset;

   assign req_id     = req_tdata[ID_W-1:0];
   assign req_offset = req_tdata[ID_W+OFF_W-1:ID_W];

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = ent[TABLE_DEPTH-1].valid;

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         logic      left_open;
         entry_type left_entry;
         entry_type right_entry;
         if (g == 0) begin : g_first
            assign left_open  = 1'b0;
            assign left_entry = '0;
         end else begin : g_mid
            assign left_open  = open[g-1];
            assign left_entry = ent[g-1];
         end
         if (g == TABLE_DEPTH - 1) begin : g_end
            assign right_entry = '0;
         end else begin : g_body
            assign right_entry = ent[g+1];
         end
         skoi_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_open   (left_open),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .open        (open[g]),
            .entry       (ent[g])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      ctrl.cmd      = CMD_HOLD;
      ctrl.key      = req_id;
      ctrl.offset   = req_offset;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_INSERT) begin
                  if (full) begin
                     rsp_valid_in  = 1'b1;
                     rsp_id_in     = req_id;
                     rsp_offset_in = req_offset;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     ctrl.cmd = CMD_INSERT;
                  end
               end else if (ent[0].valid) begin
                  state_in = ST_DRAIN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = '0;
                  rsp_offset_in = '0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
               end
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               // first cell goes out, the rest of the chain moves down one
               ctrl.cmd      = CMD_DRAIN;
               rsp_valid_in  = 1'b1;
               rsp_id_in     = ent[0].key;
               rsp_offset_in = ent[0].offset;
               rsp_last_in   = !ent[1].valid;
               rsp_status_in = STATUS_ENTRY;
               if (!ent[1].valid) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_id_ff     <= rsp_id_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(DATA_W-ID_W-OFF_W){1'b0}}, rsp_offset_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

FILE: src/skoi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skoi_checker
// Port-level checks for the sorted key/offset index unit, bound to the top.
// ----------------------------------------------------------------------------
module skoi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [skoi_pkg::DATA_W-1:0]   rsp_tdata,
   input logic                          rsp_tlast,
   input logic [skoi_pkg::STATUS_W-1:0] rsp_tuser
);
   import skoi_pkg::*;

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_ENTRY || rsp_tuser == STATUS_FULL ||
                      rsp_tuser == STATUS_EMPTY))
      else $error("unknown status code");

   a_single_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_FULL || rsp_tuser == STATUS_EMPTY)
      |-> rsp_tlast)
      else $error("single result transfer not marked last");

   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> rsp_tdata == '0)
      else $error("empty result carries data");

   // mid-drain the input side must be closed
   a_drain_closed : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_ENTRY && !rsp_tlast |-> !req_tready)
      else $error("input taken during drain");

endmodule

bind sorted_key_offset_index_unit skoi_checker u_skoi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
